// File: src/h264_sps_pkg.sv
// package: field steps, status codes and constants for the sps size parser
package h264_sps_pkg;

  localparam int MaxLeadingZeros = 32;
  localparam int MinUnitBytes    = 4;
  localparam int AccW            = 33;
  localparam int WideW           = 40;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_BAD_EG    = 3'd3,
    ST_BAD_DIM   = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    F_PROFILE, F_CONSTR, F_LEVEL, F_SPSID, F_CHROMA, F_SEPCOL, F_BDLUMA,
    F_BDCHROMA, F_BYPASS, F_MATRIX, F_LISTFLAG, F_DELTA, F_LOG2FN, F_POCTYPE,
    F_POCLSB, F_DELTAPIC, F_OFFNONREF, F_OFFTOP, F_NCYCLE, F_CYCLEOFF,
    F_MAXREF, F_GAPS, F_WIDTH, F_HEIGHT, F_FRAMEONLY, F_MBAFF, F_D8X8,
    F_CROPFLAG, F_CL, F_CR, F_CT, F_CB, F_DONE, F_ERROR
  } field_t;

  // top level sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_BITS, S_CALC_W, S_CALC_H, S_CALC_CHK, S_OUT
  } seq_t;

  // fixed width of a u(n) field, zero for an exp-golomb field
  function automatic logic [3:0] fixed_width(field_t f);
    unique case (f)
      F_PROFILE, F_CONSTR, F_LEVEL: fixed_width = 4'd8;
      F_SEPCOL, F_BYPASS, F_MATRIX, F_LISTFLAG, F_DELTAPIC, F_GAPS,
      F_FRAMEONLY, F_MBAFF, F_D8X8, F_CROPFLAG: fixed_width = 4'd1;
      default: fixed_width = 4'd0;
    endcase
  endfunction

  function automatic logic has_chroma(logic [7:0] p);
    unique case (p)
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118, 8'd128,
      8'd138, 8'd139, 8'd134, 8'd135: has_chroma = 1'b1;
      default: has_chroma = 1'b0;
    endcase
  endfunction

endpackage

// File: src/h264_sps_if.sv
// valid/ready stream interfaces for the sps size parser
interface h264_sps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface h264_sps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [30:0] width;
  logic [30:0] height;
  modport source (output valid, status, width, height, input ready);
  modport sink (input valid, status, width, height, output ready);
endinterface

// File: src/h264_sps_dimension_parser_core.sv
// top level: sps picture size parser, one payload bit per cycle while a byte is shifted
//
// Usage: bytes of one SPS NAL unit arrive on in_ (valid/ready), header byte
// first, last_byte marking the end of the unit. Each payload byte is shifted
// through the field parser one bit per clock after the cycle that accepts it,
// and no new byte is accepted while it is shifted; the header byte and removed
// 0x03 bytes are only accepted. The bit-serial field parser sets this rate.
// After the last byte the cropped size is worked out in the width, height
// and range check states in turn, then one request with status, width and
// height is presented on out_. It is held until the receiver takes it; no
// new byte is accepted meanwhile, and the parser state returns to its reset
// values once the result is taken. Units with no last byte give no result.
// Reset (rst_n low, synchronous) clears the parser to expect a new unit.
module h264_sps_dimension_parser_core (
  input logic clk,
  input logic rst_n,
  h264_sps_in_if.sink    in_s,
  h264_sps_out_if.source out_s
);
  import h264_sps_pkg::*;

  seq_t             seq_r, seq_nxt;
  logic [2:0]       byte_count_r, byte_count_nxt;
  logic [1:0]       zero_run_r, zero_run_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic             last_r, last_nxt;
  field_t           step_r, step_nxt;
  logic [5:0]       lzc_r, lzc_nxt;
  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [5:0]       left_r, left_nxt;
  logic [7:0]       profile_r, profile_nxt;
  logic [2:0]       chroma_r, chroma_nxt;
  logic [3:0]       list_idx_r, list_idx_nxt;
  logic [6:0]       list_el_r, list_el_nxt;
  logic [7:0]       last_scale_r, last_scale_nxt;
  logic [AccW-1:0]  cyc_r, cyc_nxt;
  logic [AccW-1:0]  wmb_r, wmb_nxt;
  logic [AccW-1:0]  hmu_r, hmu_nxt;
  logic             frame_only_r, frame_only_nxt;
  logic [AccW-1:0]  crop_r [4];
  logic [AccW-1:0]  crop_nxt [4];
  logic             eg_err_r, eg_err_nxt;
  logic signed [WideW-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [2:0]       status_r, status_nxt;

  // per-bit field walker signals
  logic             b;
  logic             fin;
  logic [AccW-1:0]  fval;
  logic [AccW-1:0]  acc_sh;
  field_t           nstep;
  logic [7:0]       nscale;
  logic [AccW-1:0]  mag;
  logic [3:0]       list_cnt;
  logic             go_next_list;

  // size computation helpers
  logic [1:0]       ux, ff;
  logic [2:0]       uy;
  logic [AccW:0]    crop_sum;
  logic signed [WideW-1:0] base, sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= S_IDLE;
      byte_count_r <= '0;
      zero_run_r   <= '0;
      step_r       <= F_PROFILE;
      lzc_r        <= '0;
      acc_r        <= '0;
      left_r       <= 6'd8;
      profile_r    <= '0;
      chroma_r     <= 3'd1;
      list_idx_r   <= '0;
      list_el_r    <= '0;
      last_scale_r <= 8'd8;
      cyc_r        <= '0;
      wmb_r        <= '0;
      hmu_r        <= '0;
      frame_only_r <= 1'b0;
      eg_err_r     <= 1'b0;
      bit_cnt_r    <= '0;
      last_r       <= 1'b0;
      for (int i = 0; i < 4; i++) crop_r[i] <= '0;
    end else begin
      seq_r        <= seq_nxt;
      byte_count_r <= byte_count_nxt;
      zero_run_r   <= zero_run_nxt;
      step_r       <= step_nxt;
      lzc_r        <= lzc_nxt;
      acc_r        <= acc_nxt;
      left_r       <= left_nxt;
      profile_r    <= profile_nxt;
      chroma_r     <= chroma_nxt;
      list_idx_r   <= list_idx_nxt;
      list_el_r    <= list_el_nxt;
      last_scale_r <= last_scale_nxt;
      cyc_r        <= cyc_nxt;
      wmb_r        <= wmb_nxt;
      hmu_r        <= hmu_nxt;
      frame_only_r <= frame_only_nxt;
      eg_err_r     <= eg_err_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      last_r       <= last_nxt;
      for (int i = 0; i < 4; i++) crop_r[i] <= crop_nxt[i];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    shift_r  <= shift_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    status_r <= status_nxt;
  end

  // crop units and shared crop sum for the size steps
  always_comb begin
    ff = frame_only_r ? 2'd1 : 2'd2;
    if (chroma_r == 3'd0) begin
      ux = 2'd1;
      uy = {1'b0, ff};
    end else begin
      ux = (chroma_r == 3'd1 || chroma_r == 3'd2) ? 2'd2 : 2'd1;
      uy = (chroma_r == 3'd1) ? {ff, 1'b0} : {1'b0, ff};
    end
    if (seq_r == S_CALC_W) begin
      crop_sum = {1'b0, crop_r[0]} + {1'b0, crop_r[1]};
      base     = WideW'({wmb_r + AccW'(1), 4'b0});
      sub      = (ux == 2'd2) ? WideW'({crop_sum, 1'b0}) : WideW'(crop_sum);
    end else begin
      crop_sum = {1'b0, crop_r[2]} + {1'b0, crop_r[3]};
      base     = (ff == 2'd2) ? WideW'({hmu_r + AccW'(1), 5'b0})
                              : WideW'({hmu_r + AccW'(1), 4'b0});
      sub      = (uy == 3'd4) ? WideW'({crop_sum, 2'b0}) :
                 (uy == 3'd2) ? WideW'({crop_sum, 1'b0}) : WideW'(crop_sum);
    end
  end

  // per-bit field walker: finish value and next field
  always_comb begin
    b        = shift_r[7];
    acc_sh   = {acc_r[AccW-2:0], b};
    fin      = 1'b0;
    fval     = '0;
    list_cnt = (chroma_r == 3'd3) ? 4'd12 : 4'd8;
    mag      = '0;
    nscale   = last_scale_r;
    nstep    = step_r;
    go_next_list = 1'b0;
    if (fixed_width(step_r) != 4'd0) begin
      fin  = (left_r == 6'd1);
      fval = acc_sh;
    end else if (acc_r == '0) begin
      fin  = b && (lzc_r == 6'd0);
      fval = '0;
    end else begin
      fin  = (left_r == 6'd1);
      fval = acc_sh - AccW'(1);
    end
    mag = fval[0] ? ((fval >> 1) + AccW'(1)) : (fval >> 1);
    if (fval[0]) nscale = last_scale_r + mag[7:0];
    else nscale = last_scale_r - mag[7:0];
    unique case (step_r)
      F_PROFILE:  nstep = F_CONSTR;
      F_CONSTR:   nstep = F_LEVEL;
      F_LEVEL:    nstep = F_SPSID;
      F_SPSID:    nstep = has_chroma(profile_r) ? F_CHROMA : F_LOG2FN;
      F_CHROMA:   nstep = (fval == AccW'(3)) ? F_SEPCOL : F_BDLUMA;
      F_SEPCOL:   nstep = F_BDLUMA;
      F_BDLUMA:   nstep = F_BDCHROMA;
      F_BDCHROMA: nstep = F_BYPASS;
      F_BYPASS:   nstep = F_MATRIX;
      F_MATRIX:   nstep = fval[0] ? F_LISTFLAG : F_LOG2FN;
      F_LISTFLAG: begin
        nstep = F_DELTA;
        go_next_list = !fval[0];
      end
      F_DELTA: begin
        nstep = F_DELTA;
        go_next_list = (nscale == 8'd0) ||
          ({1'b0, list_el_r} + 8'd1 >= ((list_idx_r < 4'd6) ? 8'd16 : 8'd64));
      end
      F_LOG2FN:   nstep = F_POCTYPE;
      F_POCTYPE:  nstep = (fval == '0) ? F_POCLSB :
                          (fval == AccW'(1)) ? F_DELTAPIC : F_MAXREF;
      F_POCLSB:   nstep = F_MAXREF;
      F_DELTAPIC: nstep = F_OFFNONREF;
      F_OFFNONREF: nstep = F_OFFTOP;
      F_OFFTOP:   nstep = F_NCYCLE;
      F_NCYCLE:   nstep = (fval == '0) ? F_MAXREF : F_CYCLEOFF;
      F_CYCLEOFF: nstep = (cyc_r == AccW'(1)) ? F_MAXREF : F_CYCLEOFF;
      F_MAXREF:   nstep = F_GAPS;
      F_GAPS:     nstep = F_WIDTH;
      F_WIDTH:    nstep = F_HEIGHT;
      F_HEIGHT:   nstep = F_FRAMEONLY;
      F_FRAMEONLY: nstep = fval[0] ? F_D8X8 : F_MBAFF;
      F_MBAFF:    nstep = F_D8X8;
      F_D8X8:     nstep = F_CROPFLAG;
      F_CROPFLAG: nstep = fval[0] ? F_CL : F_DONE;
      F_CL:       nstep = F_CR;
      F_CR:       nstep = F_CT;
      F_CT:       nstep = F_CB;
      F_CB:       nstep = F_DONE;
      default:    nstep = step_r;
    endcase
    if (go_next_list)
      nstep = (list_idx_r + 4'd1 < list_cnt) ? F_LISTFLAG : F_LOG2FN;
  end

  // sequencer: accept, shift bits, compute size, present result
  always_comb begin
    seq_nxt        = seq_r;
    byte_count_nxt = byte_count_r;
    zero_run_nxt   = zero_run_r;
    shift_nxt      = shift_r;
    bit_cnt_nxt    = bit_cnt_r;
    last_nxt       = last_r;
    step_nxt       = step_r;
    lzc_nxt        = lzc_r;
    acc_nxt        = acc_r;
    left_nxt       = left_r;
    profile_nxt    = profile_r;
    chroma_nxt     = chroma_r;
    list_idx_nxt   = list_idx_r;
    list_el_nxt    = list_el_r;
    last_scale_nxt = last_scale_r;
    cyc_nxt        = cyc_r;
    wmb_nxt        = wmb_r;
    hmu_nxt        = hmu_r;
    frame_only_nxt = frame_only_r;
    eg_err_nxt     = eg_err_r;
    for (int i = 0; i < 4; i++) crop_nxt[i] = crop_r[i];
    w_nxt          = w_r;
    h_nxt          = h_r;
    status_nxt     = status_r;
    in_s.ready     = 1'b0;
    out_s.valid    = 1'b0;

    unique case (seq_r)
      S_IDLE: begin
        in_s.ready = 1'b1;
        if (in_s.valid) begin
          if (byte_count_r < 3'(MinUnitBytes)) byte_count_nxt = byte_count_r + 3'd1;
          last_nxt  = in_s.last_byte;
          shift_nxt = in_s.data_byte;
          if (byte_count_r == 3'd0 ||
              (zero_run_r == 2'd2 && in_s.data_byte == 8'h03)) begin
            if (byte_count_r != 3'd0) zero_run_nxt = 2'd0;
            seq_nxt = in_s.last_byte ? S_CALC_W : S_IDLE;
          end else begin
            if (in_s.data_byte == 8'h00)
              zero_run_nxt = (zero_run_r == 2'd2) ? 2'd2 : zero_run_r + 2'd1;
            else zero_run_nxt = 2'd0;
            bit_cnt_nxt = 4'd8;
            seq_nxt     = S_BITS;
          end
        end
      end
      S_BITS: begin
        shift_nxt   = {shift_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 4'd1;
        if (bit_cnt_r == 4'd1) seq_nxt = last_r ? S_CALC_W : S_IDLE;
        if (step_r != F_DONE && step_r != F_ERROR) begin
          if (fixed_width(step_r) != 4'd0 || acc_r != '0) begin
            acc_nxt  = acc_sh;
            left_nxt = left_r - 6'd1;
          end else if (!b) begin
            lzc_nxt = lzc_r + 6'd1;
            if (lzc_r == 6'(MaxLeadingZeros)) begin
              eg_err_nxt = 1'b1;
              step_nxt   = F_ERROR;
            end
          end else begin
            acc_nxt  = AccW'(1);
            left_nxt = lzc_r;
          end
          if (fin) begin
            // per-field side effects
            unique case (step_r)
              F_PROFILE: profile_nxt = fval[7:0];
              F_CHROMA:  chroma_nxt = (fval <= AccW'(3)) ? fval[2:0] : 3'd4;
              F_MATRIX:  list_idx_nxt = '0;
              F_LISTFLAG: if (fval[0]) begin
                list_el_nxt = '0;
                last_scale_nxt = 8'd8;
              end
              F_DELTA: begin
                if (nscale != 8'd0) last_scale_nxt = nscale;
                list_el_nxt = list_el_r + 7'd1;
              end
              F_NCYCLE:  cyc_nxt = fval;
              F_CYCLEOFF: cyc_nxt = cyc_r - AccW'(1);
              F_WIDTH:   wmb_nxt = fval;
              F_HEIGHT:  hmu_nxt = fval;
              F_FRAMEONLY: frame_only_nxt = fval[0];
              F_CL: crop_nxt[0] = fval;
              F_CR: crop_nxt[1] = fval;
              F_CT: crop_nxt[2] = fval;
              F_CB: crop_nxt[3] = fval;
              default: ;
            endcase
            if (go_next_list) list_idx_nxt = list_idx_r + 4'd1;
            step_nxt = nstep;
            acc_nxt  = '0;
            lzc_nxt  = '0;
            left_nxt = 6'(fixed_width(nstep));
          end
        end
      end
      S_CALC_W: begin
        w_nxt   = base - sub;
        seq_nxt = S_CALC_H;
      end
      S_CALC_H: begin
        h_nxt   = base - sub;
        seq_nxt = S_CALC_CHK;
      end
      S_CALC_CHK: begin
        if (byte_count_r < 3'(MinUnitBytes)) status_nxt = ST_SHORT;
        else if (eg_err_r) status_nxt = ST_BAD_EG;
        else if (step_r != F_DONE) status_nxt = ST_TRUNC;
        else if (w_r <= 0 || h_r <= 0 || w_r > 40'sh7FFFFFFF || h_r > 40'sh7FFFFFFF)
          status_nxt = ST_BAD_DIM;
        else status_nxt = ST_OK;
        seq_nxt = S_OUT;
      end
      S_OUT: begin
        out_s.valid = 1'b1;
        if (out_s.ready) begin
          seq_nxt        = S_IDLE;
          byte_count_nxt = '0;
          zero_run_nxt   = '0;
          step_nxt       = F_PROFILE;
          lzc_nxt        = '0;
          acc_nxt        = '0;
          left_nxt       = 6'd8;
          profile_nxt    = '0;
          chroma_nxt     = 3'd1;
          list_idx_nxt   = '0;
          list_el_nxt    = '0;
          last_scale_nxt = 8'd8;
          cyc_nxt        = '0;
          wmb_nxt        = '0;
          hmu_nxt        = '0;
          frame_only_nxt = 1'b0;
          eg_err_nxt     = 1'b0;
          for (int i = 0; i < 4; i++) crop_nxt[i] = '0;
        end
      end
      default: seq_nxt = S_IDLE;
    endcase
  end

  // result payload
  assign out_s.status = status_r;
  assign out_s.width  = (status_r == ST_OK) ? w_r[30:0] : '0;
  assign out_s.height = (status_r == ST_OK) ? h_r[30:0] : '0;

  // checks
  a_no_ready_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> !in_s.ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && !out_s.ready |=> out_s.valid && $stable(out_s.status))
    else $error("result dropped under stall");
  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    eg_err_r |-> step_r == F_ERROR) else $error("eg error without error step");
  a_bits_count: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == S_BITS |-> bit_cnt_r != 4'd0) else $error("bit counter underflow");
endmodule

// File: bench/tb_h264_sps_dimension_parser_core.sv
// testbench: sps picture size parser checked against a bit-serial predictor
module tb_h264_sps_dimension_parser_core;
  import h264_sps_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] width;
    logic [30:0] height;
  } size_result_t;

  typedef enum int {
    U_GOOD, U_SHORT, U_TRUNC, U_BAD_EG, U_NOISE, U_UNESCAPED
  } unit_kind_t;

  localparam bit [7:0] ChromaProfiles [13] = '{
    8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118, 8'd128,
    8'd138, 8'd139, 8'd134, 8'd135
  };

  function automatic bit profile_has_chroma(bit [7:0] p);
    foreach (ChromaProfiles[i]) begin
      if (ChromaProfiles[i] == p) return 1'b1;
    end
    return 1'b0;
  endfunction

  // predictor of the parser plus the store of expected sizes
  class sps_size_scoreboard;
    size_result_t expected_sizes[$];
    int errors;
    int results_seen;
    int nbytes;
    bit [1:0] zrun;
    field_t step;
    int lzc;
    bit [32:0] acc;
    int bleft;
    bit [7:0] prof;
    bit [2:0] cclass;
    int lidx;
    int lel;
    bit [7:0] last_sc;
    bit [7:0] next_sc;
    bit [32:0] ncyc;
    bit [32:0] wm1;
    bit [32:0] hm1;
    bit fo;
    bit [32:0] crop [4];
    bit [2:0] err;

    function new();
      errors = 0;
      results_seen = 0;
      clear_unit();
    endfunction

    function int field_bits(field_t s);
      case (s)
        F_PROFILE, F_CONSTR, F_LEVEL: return 8;
        F_SEPCOL, F_BYPASS, F_MATRIX, F_LISTFLAG, F_DELTAPIC, F_GAPS,
        F_FRAMEONLY, F_MBAFF, F_D8X8, F_CROPFLAG: return 1;
        default: return 0;
      endcase
    endfunction

    function void enter(field_t s);
      step = s;
      acc = '0;
      lzc = 0;
      bleft = field_bits(s);
    endfunction

    function void clear_unit();
      nbytes = 0;
      zrun = 0;
      enter(F_PROFILE);
      prof = 0;
      cclass = 3'd1;
      lidx = 0;
      lel = 0;
      last_sc = 8'd8;
      next_sc = 8'd8;
      ncyc = '0;
      wm1 = '0;
      hm1 = '0;
      fo = 1'b0;
      foreach (crop[i]) crop[i] = '0;
      err = ST_OK;
    endfunction

    function void next_list();
      lidx++;
      if (lidx < ((cclass == 3) ? 12 : 8)) enter(F_LISTFLAG);
      else enter(F_LOG2FN);
    endfunction

    // field complete: record it and pick the next one
    function void field_done(bit [32:0] v);
      bit [32:0] mag;
      case (step)
        F_PROFILE: begin
          prof = v[7:0];
          enter(F_CONSTR);
        end
        F_CONSTR: enter(F_LEVEL);
        F_LEVEL: enter(F_SPSID);
        F_SPSID: enter(profile_has_chroma(prof) ? F_CHROMA : F_LOG2FN);
        F_CHROMA: begin
          cclass = (v <= 3) ? v[2:0] : 3'd4;
          enter(v == 3 ? F_SEPCOL : F_BDLUMA);
        end
        F_SEPCOL: enter(F_BDLUMA);
        F_BDLUMA: enter(F_BDCHROMA);
        F_BDCHROMA: enter(F_BYPASS);
        F_BYPASS: enter(F_MATRIX);
        F_MATRIX: begin
          lidx = 0;
          enter(v[0] ? F_LISTFLAG : F_LOG2FN);
        end
        F_LISTFLAG: begin
          if (v[0]) begin
            lel = 0;
            last_sc = 8'd8;
            next_sc = 8'd8;
            enter(F_DELTA);
          end else begin
            next_list();
          end
        end
        F_DELTA: begin
          mag = v[0] ? (v >> 1) + 1 : (v >> 1);
          if (v[0]) next_sc = last_sc + mag[7:0];
          else next_sc = last_sc - mag[7:0];
          if (next_sc != 0) last_sc = next_sc;
          lel++;
          if (next_sc == 0 || lel >= ((lidx < 6) ? 16 : 64)) next_list();
          else enter(F_DELTA);
        end
        F_LOG2FN: enter(F_POCTYPE);
        F_POCTYPE: begin
          if (v == 0) enter(F_POCLSB);
          else if (v == 1) enter(F_DELTAPIC);
          else enter(F_MAXREF);
        end
        F_POCLSB: enter(F_MAXREF);
        F_DELTAPIC: enter(F_OFFNONREF);
        F_OFFNONREF: enter(F_OFFTOP);
        F_OFFTOP: enter(F_NCYCLE);
        F_NCYCLE: begin
          ncyc = v;
          enter(v == 0 ? F_MAXREF : F_CYCLEOFF);
        end
        F_CYCLEOFF: begin
          ncyc = ncyc - 1;
          enter(ncyc == 0 ? F_MAXREF : F_CYCLEOFF);
        end
        F_MAXREF: enter(F_GAPS);
        F_GAPS: enter(F_WIDTH);
        F_WIDTH: begin
          wm1 = v;
          enter(F_HEIGHT);
        end
        F_HEIGHT: begin
          hm1 = v;
          enter(F_FRAMEONLY);
        end
        F_FRAMEONLY: begin
          fo = v[0];
          enter(fo ? F_D8X8 : F_MBAFF);
        end
        F_MBAFF: enter(F_D8X8);
        F_D8X8: enter(F_CROPFLAG);
        F_CROPFLAG: enter(v[0] ? F_CL : F_DONE);
        F_CL: begin
          crop[0] = v;
          enter(F_CR);
        end
        F_CR: begin
          crop[1] = v;
          enter(F_CT);
        end
        F_CT: begin
          crop[2] = v;
          enter(F_CB);
        end
        F_CB: begin
          crop[3] = v;
          enter(F_DONE);
        end
        default: ;
      endcase
    endfunction

    // one payload bit through the u(n) or exp-golomb reader
    function void shift_bit(bit b);
      if (step >= F_DONE) return;
      if (field_bits(step) > 0) begin
        acc = {acc[31:0], b};
        bleft--;
        if (bleft == 0) field_done(acc);
      end else if (acc == 0) begin
        if (!b) begin
          lzc++;
          if (lzc > MaxLeadingZeros) begin
            err = ST_BAD_EG;
            step = F_ERROR;
          end
        end else begin
          acc = 33'd1;
          bleft = lzc;
          if (bleft == 0) field_done('0);
        end
      end else begin
        acc = {acc[31:0], b};
        bleft--;
        if (bleft == 0) field_done(acc - 1);
      end
    endfunction

    function void note_request(bit [7:0] b, bit lst);
      bit first;
      longint f, ux, uy, w, h;
      size_result_t r;
      first = (nbytes == 0);
      if (nbytes < MinUnitBytes) nbytes++;
      if (!first) begin
        // emulation prevention byte is dropped
        if (zrun >= 2 && b == 8'h03) begin
          zrun = 0;
        end else begin
          zrun = (b == 0) ? ((zrun < 2) ? zrun + 2'd1 : 2'd2) : 2'd0;
          for (int i = 7; i >= 0; i--) shift_bit(b[i]);
        end
      end
      if (!lst) return;
      r = '0;
      if (nbytes < MinUnitBytes) r.status = ST_SHORT;
      else if (err == ST_BAD_EG) r.status = ST_BAD_EG;
      else if (step != F_DONE) r.status = ST_TRUNC;
      else begin
        f = fo ? 1 : 2;
        if (cclass == 0) begin
          ux = 1;
          uy = f;
        end else begin
          ux = (cclass == 1 || cclass == 2) ? 2 : 1;
          uy = ((cclass == 1) ? 2 : 1) * f;
        end
        w = (longint'(wm1) + 1) * 16 - ux * (longint'(crop[0]) + longint'(crop[1]));
        h = f * (longint'(hm1) + 1) * 16 - uy * (longint'(crop[2]) + longint'(crop[3]));
        if (w <= 0 || h <= 0 || w > 64'h7FFF_FFFF || h > 64'h7FFF_FFFF) begin
          r.status = ST_BAD_DIM;
        end else begin
          r.status = ST_OK;
          r.width = w[30:0];
          r.height = h[30:0];
        end
      end
      expected_sizes = {expected_sizes, r};
      clear_unit();
    endfunction

    function void check_result(logic [2:0] st, logic [30:0] w, logic [30:0] h);
      size_result_t e;
      results_seen++;
      if (expected_sizes.size() == 0) begin
        $error("unexpected result: status %0d width %0d height %0d", st, w, h);
        errors++;
        return;
      end
      e = expected_sizes.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (w !== e.width) begin
        $error("width: expected %0d, got %0d", e.width, w);
        errors++;
      end
      if (h !== e.height) begin
        $error("height: expected %0d, got %0d", e.height, h);
        errors++;
      end
    endfunction

    function int pending();
      return expected_sizes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int bytes_sent = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  bit rbsp_bits[$];
  bit [7:0] unit_bytes[$];
  sps_size_scoreboard sb;

  h264_sps_in_if in_if ();
  h264_sps_out_if out_if ();

  h264_sps_dimension_parser_core dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_if),
    .out_s(out_if)
  );

  always #4 clk = ~clk;

  // run limit
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver stall pattern, changes mode now and then
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= $urandom_range(0, 1);
      default: out_if.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // accepted requests on both channels
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_request(in_if.data_byte, in_if.last_byte);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.status, out_if.width, out_if.height);
    end
  end

  task automatic put_u(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) rbsp_bits = {rbsp_bits, v[i]};
  endtask

  task automatic put_ue(longint unsigned v);
    longint unsigned c;
    int n;
    c = v + 1;
    n = 0;
    while ((c >> n) != 0) n++;
    repeat (n - 1) rbsp_bits = {rbsp_bits, 1'b0};
    put_u(c, n);
  endtask

  task automatic put_se(int d);
    if (d > 0) put_ue(2 * d - 1);
    else put_ue(-2 * d);
  endtask

  // mostly small, sometimes huge, rarely the largest exp-golomb value
  function automatic longint unsigned pick_size(int lo, int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 64'h1_FFFF_FFFE;
    if (r < 3) return longint'($urandom);
    return $urandom_range(lo, hi);
  endfunction

  // well-formed sps payload with random content
  task automatic gen_sps();
    bit [7:0] prof;
    int cc, rnd, poc, ncyc, lastv, nxt, d, fsize;
    bit fo, crop_on;
    prof = ($urandom_range(0, 2) != 0) ? ChromaProfiles[$urandom_range(0, 12)]
                                        : 8'($urandom_range(0, 255));
    put_u(prof, 8);
    put_u($urandom_range(0, 255), 8);
    put_u($urandom_range(0, 255), 8);
    put_ue($urandom_range(0, 31));
    if (profile_has_chroma(prof)) begin
      cc = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 300);
      put_ue(cc);
      if (cc == 3) put_u($urandom_range(0, 1), 1);
      put_ue($urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      put_u($urandom_range(0, 1), 1);
      if ($urandom_range(0, 3) == 0) begin
        put_u(1, 1);
        for (int li = 0; li < ((cc == 3) ? 12 : 8); li++) begin
          if ($urandom_range(0, 2) == 0) begin
            put_u(1, 1);
            fsize = (li < 6) ? 16 : 64;
            lastv = 8;
            for (int e = 0; e < fsize; e++) begin
              d = ($urandom_range(0, 5) == 0) ? -lastv : $urandom_range(0, 255) - 128;
              put_se(d);
              nxt = (lastv + d) & 255;
              if (nxt == 0) break;
              lastv = nxt;
            end
          end else begin
            put_u(0, 1);
          end
        end
      end else begin
        put_u(0, 1);
      end
    end
    put_ue($urandom_range(0, 12));
    rnd = $urandom_range(0, 9);
    poc = (rnd < 4) ? 0 : (rnd < 8) ? 1 : (rnd == 8) ? 2 : $urandom_range(3, 1000);
    put_ue(poc);
    if (poc == 0) begin
      put_ue($urandom_range(0, 12));
    end else if (poc == 1) begin
      put_u($urandom_range(0, 1), 1);
      put_se($urandom_range(0, 2000) - 1000);
      put_se($urandom_range(0, 2000) - 1000);
      ncyc = $urandom_range(0, 4);
      put_ue(ncyc);
      repeat (ncyc) put_se($urandom_range(0, 200) - 100);
    end
    put_ue($urandom_range(0, 16));
    put_u($urandom_range(0, 1), 1);
    put_ue(pick_size(0, 119));
    put_ue(pick_size(0, 67));
    fo = $urandom_range(0, 1);
    put_u(fo, 1);
    if (!fo) put_u($urandom_range(0, 1), 1);
    put_u($urandom_range(0, 1), 1);
    crop_on = $urandom_range(0, 1);
    put_u(crop_on, 1);
    if (crop_on) begin
      repeat (4) put_ue(($urandom_range(0, 5) == 0) ? pick_size(0, 1 << 20) : $urandom_range(0, 8));
    end
    // stop bit and alignment
    rbsp_bits = {rbsp_bits, 1'b1};
    while (rbsp_bits.size() % 8 != 0) rbsp_bits = {rbsp_bits, 1'b0};
  endtask

  task automatic send_byte(bit [7:0] b, bit lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= lst;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_unit();
    for (int i = 0; i < unit_bytes.size(); i++) begin
      send_byte(unit_bytes[i], i == unit_bytes.size() - 1);
    end
  endtask

  // build one unit of the given kind into unit_bytes
  task automatic build_unit(unit_kind_t kind);
    bit [7:0] raw[$];
    bit [7:0] b;
    int zr, pos, cut;
    rbsp_bits.delete();
    unit_bytes.delete();
    unit_bytes = {unit_bytes,
                  (($urandom_range(0, 1) == 0) ? 8'h67 : 8'($urandom_range(0, 255)))};
    if (kind == U_SHORT || kind == U_NOISE) begin
      repeat ((kind == U_SHORT) ? $urandom_range(0, 2) : $urandom_range(3, 20)) begin
        unit_bytes = {unit_bytes,
                      (($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255)))};
      end
      return;
    end
    gen_sps();
    if (kind == U_BAD_EG) begin
      pos = ($urandom_range(0, 1) == 0) ? 24 : $urandom_range(0, rbsp_bits.size());
      repeat ($urandom_range(33, 45)) rbsp_bits.insert(pos, 1'b0);
      while (rbsp_bits.size() % 8 != 0) rbsp_bits = {rbsp_bits, 1'b0};
    end
    for (int i = 0; i < rbsp_bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = rbsp_bits[i + k];
      raw = {raw, b};
    end
    if (kind == U_TRUNC) begin
      cut = $urandom_range(1, (raw.size() > 3) ? raw.size() - 3 : 1);
      repeat (cut) void'(raw.pop_back());
    end
    // insert emulation prevention unless the unit is left raw
    zr = 0;
    foreach (raw[i]) begin
      if (kind != U_UNESCAPED && zr >= 2 && raw[i] <= 8'h03) begin
        unit_bytes = {unit_bytes, 8'h03};
        zr = 0;
      end
      unit_bytes = {unit_bytes, raw[i]};
      zr = (raw[i] == 0) ? zr + 1 : 0;
    end
  endtask

  task automatic directed_unit(bit [7:0] a, bit [7:0] b, bit [7:0] c, bit [7:0] d, int n);
    bit [7:0] seq[4];
    seq = '{a, b, c, d};
    unit_bytes.delete();
    for (int i = 0; i < n; i++) unit_bytes = {unit_bytes, seq[i]};
    send_unit();
  endtask

  initial begin
    int r, units;
    unit_kind_t kind;
    sb = new();
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short units, emulation prevention and all-ones payload
    directed_unit(8'hFF, 8'h00, 8'h00, 8'h00, 1);
    directed_unit(8'h00, 8'hFF, 8'h00, 8'h00, 2);
    directed_unit(8'h67, 8'h00, 8'hFF, 8'h00, 3);
    directed_unit(8'h67, 8'h00, 8'h00, 8'h03, 4);
    directed_unit(8'h67, 8'hFF, 8'hFF, 8'hFF, 4);
    build_unit(U_GOOD);
    send_unit();

    // random units
    units = 0;
    while (bytes_sent < 450) begin
      r = $urandom_range(0, 19);
      kind = (r < 12) ? U_GOOD : (r < 14) ? U_TRUNC : (r < 16) ? U_BAD_EG :
             (r < 18) ? U_NOISE : (r == 18) ? U_SHORT : U_UNESCAPED;
      build_unit(kind);
      send_unit();
      units++;
      // hold off until the parser has drained
      if (units == 6) begin
        in_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
